### rtl/tccc_pkg.sv
`timescale 1ns / 1ps

package tccc_pkg;

	// Layout constants
	localparam int unsigned MARGIN       = 16;
	localparam int unsigned TAB_CELLS    = 8;
	localparam int unsigned TAB_W_NARROW = TAB_CELLS * 4;
	localparam int unsigned TAB_W_WIDE   = TAB_CELLS * 8;

	// Output word queue
	localparam int unsigned OUTQ_DEPTH = 4;
	localparam int unsigned OUTQ_AW    = $clog2(OUTQ_DEPTH);

	// Configuration register indexes
	localparam logic [1:0] CFG_ENABLE = 2'd0;
	localparam logic [1:0] CFG_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_HEIGHT = 2'd2;
	localparam logic [1:0] CFG_FONT   = 2'd3;

	// Font select codes
	localparam logic [1:0] FONT_4X6  = 2'd0;
	localparam logic [1:0] FONT_8X8  = 2'd1;
	localparam logic [1:0] FONT_8X16 = 2'd2;

	// Control characters
	localparam logic [7:0] CHAR_BS  = 8'd8;
	localparam logic [7:0] CHAR_TAB = 8'd9;
	localparam logic [7:0] CHAR_LF  = 8'd10;
	localparam logic [7:0] CHAR_CR  = 8'd13;

	localparam logic [6:0] GLYPH_SUB = 7'd63; // '?'

	typedef enum logic [1:0] {
		OP_PUT_CHAR = 2'd0,
		OP_SET_PEN  = 2'd1,
		OP_CLEAR    = 2'd2
	} op_e_t;

	typedef enum logic [1:0] {
		ACT_DRAW   = 2'd0,
		ACT_ERASE  = 2'd1,
		ACT_SCROLL = 2'd2,
		ACT_CLEAR  = 2'd3
	} act_e_t;

	typedef struct packed {
		logic        enable;
		logic [12:0] width;
		logic [12:0] height;
		logic [1:0]  font;
	} cfg_t;

	typedef struct packed {
		act_e_t      action;
		logic [12:0] cell_x;
		logic [12:0] cell_y;
		logic [6:0]  glyph_code;
		logic        last_of_run;
	} res_t;

	typedef struct packed {
		res_t       r0;
		res_t       r1;
		logic [1:0] count;
	} step_res_t;

	function automatic res_t mk_res(act_e_t act, logic [12:0] x, logic [12:0] y,
		logic [6:0] g);
		res_t r;
		r.action      = act;
		r.cell_x      = x;
		r.cell_y      = y;
		r.glyph_code  = g;
		r.last_of_run = 1'b0;
		return r;
	endfunction

endpackage

### rtl/text_console_cursor_control_top.sv
`timescale 1ns / 1ps

// Text console cursor control.
// Input channel (in_valid/in_ready) takes one word per operation: put
// character, set pen or clear screen. Output channel (out_valid/out_ready)
// delivers drawing commands, at most two per input word, the final one
// flagged by last_of_run. The cfg channel (cfg_valid/cfg_ready, always
// ready) writes enable, screen width, screen height and font select; write
// it only while no work is in flight.
// A word in the input register moves through the core into the output queue
// once the queue has room; its first command shows on out_valid once it is
// queued. Throughput: one input word per cycle while each makes at most one
// command and out_ready stays high; words making two commands (scroll then
// draw) are paced by the one-word-per-cycle drain of the four-entry queue.
// Reset clears the pen to the margin, loads the config reset values
// (console disabled) and empties the pipeline and queue.
// When the receiver stalls, the queue fills; the input register holds its
// word and in_ready falls once fewer than two queue slots are free.
module text_console_cursor_control_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [7:0]  char_code,
	input  logic [11:0] new_pen_x,
	input  logic [11:0] new_pen_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  action,
	output logic [12:0] cell_x,
	output logic [12:0] cell_y,
	output logic [6:0]  glyph_code,
	output logic        last_of_run,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	tccc_pkg::cfg_t      cfg_q;
	tccc_pkg::step_res_t core_res;
	tccc_pkg::res_t      head;
	logic                q_room;
	logic                take;

	// Input register
	logic        valid_s1;
	logic [1:0]  opcode_s1;
	logic [7:0]  char_s1;
	logic [11:0] pen_x_s1, pen_y_s1;

	// Config registers, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable <= 1'b0;
			cfg_q.width  <= 13'd640;
			cfg_q.height <= 13'd480;
			cfg_q.font   <= tccc_pkg::FONT_8X8;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tccc_pkg::CFG_ENABLE: cfg_q.enable <= cfg_data[0];
				tccc_pkg::CFG_WIDTH:  cfg_q.width  <= cfg_data;
				tccc_pkg::CFG_HEIGHT: cfg_q.height <= cfg_data;
				tccc_pkg::CFG_FONT:   cfg_q.font   <= cfg_data[1:0];
			endcase
		end
	end

	// The stage-1 word moves into the core when the queue can take two words
	assign take     = valid_s1 && q_room;
	assign in_ready = !valid_s1 || q_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1 <= opcode;
			char_s1   <= char_code;
			pen_x_s1  <= new_pen_x;
			pen_y_s1  <= new_pen_y;
		end
	end

	tccc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (take),
		.opcode    (opcode_s1),
		.char_code (char_s1),
		.new_pen_x (pen_x_s1),
		.new_pen_y (pen_y_s1),
		.cfg       (cfg_q),
		.res       (core_res)
	);

	tccc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (core_res),
		.room      (q_room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign action      = head.action;
	assign cell_x      = head.cell_x;
	assign cell_y      = head.cell_y;
	assign glyph_code  = head.glyph_code;
	assign last_of_run = head.last_of_run;

endmodule

### rtl/tccc_core.sv
`timescale 1ns / 1ps

// Pen state and per-word command generation, one word per cycle while step is high.
module tccc_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [1:0]             opcode,
	input  logic [7:0]             char_code,
	input  logic [11:0]            new_pen_x,
	input  logic [11:0]            new_pen_y,
	input  tccc_pkg::cfg_t         cfg,
	output tccc_pkg::step_res_t    res
);

	localparam logic [12:0] MARGIN_POS = 13'(tccc_pkg::MARGIN);

	logic [12:0] pen_col_q, pen_row_q;
	logic [12:0] nxt_col, nxt_row;

	logic [3:0]  fw;
	logic [4:0]  fh;
	logic [14:0] lf_row_a;
	logic        lf_scroll;
	logic [12:0] lf_row;
	logic [12:0] bs_col;
	logic [12:0] tab_v, tab_rem;
	logic [14:0] tab_w, tab_col;
	logic        tab_wrap;
	logic        chr_wrap;
	logic [6:0]  glyph;
	tccc_pkg::res_t r0, r1;
	logic [1:0]  n;

	always_comb begin
		fw = (cfg.font == tccc_pkg::FONT_4X6) ? 4'd4 : 4'd8;
		unique case (cfg.font)
			tccc_pkg::FONT_4X6:  fh = 5'd6;
			tccc_pkg::FONT_8X16: fh = 5'd16;
			default:             fh = 5'd8;
		endcase
	end

	// Line feed: scroll if the new line would pass the bottom
	assign lf_row_a  = {2'b0, pen_row_q} + {10'b0, fh};
	assign lf_scroll = (lf_row_a + {10'b0, fh}) > {2'b0, cfg.height};
	assign lf_row    = lf_scroll ? pen_row_q : lf_row_a[12:0];

	// Backspace saturates at zero
	assign bs_col = (pen_col_q >= {9'b0, fw}) ? pen_col_q - {9'b0, fw} : 13'd0;

	// Tab: next stop past the margin
	assign tab_v   = pen_col_q - MARGIN_POS;
	assign tab_w   = (cfg.font == tccc_pkg::FONT_4X6) ? 15'(tccc_pkg::TAB_W_NARROW)
		: 15'(tccc_pkg::TAB_W_WIDE);
	assign tab_rem = (cfg.font == tccc_pkg::FONT_4X6) ? 13'(tab_v % tccc_pkg::TAB_W_NARROW)
		: 13'(tab_v % tccc_pkg::TAB_W_WIDE);
	assign tab_col = (pen_col_q < MARGIN_POS) ? {2'b0, MARGIN_POS}
		: {2'b0, MARGIN_POS} + {2'b0, tab_v} + tab_w - {2'b0, tab_rem};
	assign tab_wrap = (tab_col + {11'b0, fw}) > {2'b0, cfg.width};

	assign chr_wrap = ({2'b0, pen_col_q} + {11'b0, fw} + {2'b0, MARGIN_POS})
		> {2'b0, cfg.width};
	assign glyph    = char_code[7] ? tccc_pkg::GLYPH_SUB : char_code[6:0];

	always_comb begin
		nxt_col = pen_col_q;
		nxt_row = pen_row_q;
		r0      = '0;
		r1      = '0;
		n       = 2'd0;
		if (step && cfg.enable) begin
			unique case (tccc_pkg::op_e_t'(opcode))
				tccc_pkg::OP_SET_PEN: begin
					nxt_col = {1'b0, new_pen_x};
					nxt_row = {1'b0, new_pen_y};
				end
				tccc_pkg::OP_CLEAR: begin
					r0      = tccc_pkg::mk_res(tccc_pkg::ACT_CLEAR, 13'd0, 13'd0, 7'd0);
					n       = 2'd1;
					nxt_col = MARGIN_POS;
					nxt_row = MARGIN_POS;
				end
				tccc_pkg::OP_PUT_CHAR: begin
					unique case (char_code)
						tccc_pkg::CHAR_CR: nxt_col = MARGIN_POS;
						tccc_pkg::CHAR_LF: begin
							nxt_col = MARGIN_POS;
							nxt_row = lf_row;
							if (lf_scroll) begin
								r0 = tccc_pkg::mk_res(tccc_pkg::ACT_SCROLL, 13'd0, 13'd0, 7'd0);
								n  = 2'd1;
							end
						end
						tccc_pkg::CHAR_BS: begin
							if (pen_col_q > MARGIN_POS) begin
								nxt_col = bs_col;
								r0 = tccc_pkg::mk_res(tccc_pkg::ACT_ERASE, bs_col, pen_row_q, 7'd0);
								n  = 2'd1;
							end
						end
						tccc_pkg::CHAR_TAB: begin
							if (tab_wrap) begin
								nxt_col = MARGIN_POS;
								nxt_row = lf_row;
								if (lf_scroll) begin
									r0 = tccc_pkg::mk_res(tccc_pkg::ACT_SCROLL, 13'd0, 13'd0, 7'd0);
									n  = 2'd1;
								end
							end else begin
								nxt_col = tab_col[12:0];
							end
						end
						default: begin
							if (chr_wrap) begin
								nxt_row = lf_row;
								nxt_col = MARGIN_POS + {9'b0, fw};
								if (lf_scroll) begin
									r0 = tccc_pkg::mk_res(tccc_pkg::ACT_SCROLL, 13'd0, 13'd0, 7'd0);
									r1 = tccc_pkg::mk_res(tccc_pkg::ACT_DRAW, MARGIN_POS, lf_row, glyph);
									n  = 2'd2;
								end else begin
									r0 = tccc_pkg::mk_res(tccc_pkg::ACT_DRAW, MARGIN_POS, lf_row, glyph);
									n  = 2'd1;
								end
							end else begin
								nxt_col = pen_col_q + {9'b0, fw};
								r0 = tccc_pkg::mk_res(tccc_pkg::ACT_DRAW, pen_col_q, pen_row_q, glyph);
								n  = 2'd1;
							end
						end
					endcase
				end
				default: ; // reserved opcode, ignored
			endcase
		end
		if (n == 2'd1) r0.last_of_run = 1'b1;
		if (n == 2'd2) r1.last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_col_q <= MARGIN_POS;
			pen_row_q <= MARGIN_POS;
		end else begin
			pen_col_q <= nxt_col;
			pen_row_q <= nxt_row;
		end
	end

	assign res.r0    = r0;
	assign res.r1    = r1;
	assign res.count = n;

endmodule

### rtl/tccc_outq.sv
`timescale 1ns / 1ps

// Small result queue: up to two words in, one word out per cycle while out_ready is high.
module tccc_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  tccc_pkg::step_res_t push,
	output logic                room,
	output logic                out_valid,
	input  logic                out_ready,
	output tccc_pkg::res_t      head
);

	localparam int unsigned AW = tccc_pkg::OUTQ_AW;

	tccc_pkg::res_t mem_q [tccc_pkg::OUTQ_DEPTH];
	logic [AW-1:0]  wr_q, rd_q;
	logic [AW:0]    cnt_q;
	logic           pop;
	logic [AW-1:0]  wr_nxt1;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign head      = mem_q[rd_q];
	assign room      = cnt_q <= (AW+1)'(tccc_pkg::OUTQ_DEPTH - 2);
	assign wr_nxt1   = wr_q + AW'(1);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) mem_q[wr_q] <= push.r0;
		if (push.count == 2'd2) mem_q[wr_nxt1] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + AW'(push.count);
			if (pop) rd_q <= rd_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push.count) - (AW+1)'(pop);
		end
	end

endmodule

### rtl/tccc_checker.sv
`timescale 1ns / 1ps

module tccc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  action,
	input logic [12:0] cell_x,
	input logic [12:0] cell_y,
	input logic [6:0]  glyph_code,
	input logic        last_of_run
);

	// Stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(action) && $stable(cell_x)
			&& $stable(cell_y) && $stable(glyph_code) && $stable(last_of_run))
		else $error("output word changed while stalled");

	// Scroll and clear carry no position or glyph
	a_no_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == tccc_pkg::ACT_SCROLL || action == tccc_pkg::ACT_CLEAR)
			|-> cell_x == 13'd0 && cell_y == 13'd0 && glyph_code == 7'd0)
		else $error("scroll/clear with nonzero fields");

	// Erase is the only command of its input and has no glyph
	a_erase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == tccc_pkg::ACT_ERASE |-> last_of_run && glyph_code == 7'd0)
		else $error("bad erase word");

	// Clear always ends its run
	a_clear_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == tccc_pkg::ACT_CLEAR |-> last_of_run)
		else $error("clear not last of run");

endmodule

bind text_console_cursor_control_top tccc_checker u_tccc_checker (.*);
